// ===== src/lsmc_pkg.sv =====
// shared types, constants and helpers for the limit switch motor controller
`default_nettype none

package lsmc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_LOCKOUT_PASSES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CURRENT_OFFSET = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MARGIN_SHIFT   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIGHT_DELAY_MS = 2'd3;

  localparam int unsigned CfgDataW = 22;
  localparam int unsigned CurW     = 10;
  localparam int unsigned LockW    = 4;
  localparam int unsigned ShiftW   = 3;
  localparam int unsigned DelayW   = 22;
  localparam int unsigned RunW     = 3;

  // register reset values
  localparam logic [LockW-1:0]  LOCKOUT_RST = 4'd3;
  localparam logic [CurW-1:0]   OFFSET_RST  = 10'd511;
  localparam logic [ShiftW-1:0] SHIFT_RST   = 3'd3;
  localparam logic [DelayW-1:0] DELAY_RST   = 22'd900000;

  // item kinds
  localparam logic ACT_PASS = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // relay bit positions
  localparam int unsigned RLY_A     = 0;
  localparam int unsigned RLY_B     = 1;
  localparam int unsigned RLY_LIGHT = 2;

  // run-state codes as seen on the result
  localparam logic [RunW-1:0] RUN_INIT     = 3'd0;
  localparam logic [RunW-1:0] RUN_AT_A     = 3'd1;
  localparam logic [RunW-1:0] RUN_AT_B     = 3'd2;
  localparam logic [RunW-1:0] RUN_A_TO_B   = 3'd3;
  localparam logic [RunW-1:0] RUN_B_TO_A   = 3'd4;
  localparam logic [RunW-1:0] RUN_PAUSE_AB = 3'd5;
  localparam logic [RunW-1:0] RUN_PAUSE_BA = 3'd6;

  // motion state machine, one-hot
  typedef enum logic [6:0] {
    ST_INIT     = 7'b0000001,
    ST_AT_A     = 7'b0000010,
    ST_AT_B     = 7'b0000100,
    ST_A_TO_B   = 7'b0001000,
    ST_B_TO_A   = 7'b0010000,
    ST_PAUSE_AB = 7'b0100000,
    ST_PAUSE_BA = 7'b1000000
  } motion_e;

  typedef struct packed {
    logic [LockW-1:0]  lockout_passes;
    logic [CurW-1:0]   current_offset;
    logic [ShiftW-1:0] margin_shift;
    logic [DelayW-1:0] light_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic            action;
    logic            touch_pressed;
    logic            limit_a_closed;
    logic            limit_b_closed;
    logic            limit_c_closed;
    logic [CurW-1:0] current_sample;
    logic [CurW-1:0] start_current;
  } item_t;

  typedef struct packed {
    motion_e           motion;
    logic [LockW-1:0]  lockout_count;
    logic              touch_locked;
    logic [CurW-1:0]   ref_current;
    logic              light_idle;
    logic [DelayW-1:0] light_count;
    logic [2:0]        relay;
    logic              led_a_pin;
    logic              indicator;
  } ctl_state_t;

  typedef struct packed {
    logic            relay_a_on;
    logic            relay_b_on;
    logic            light_relay_on;
    logic            led_a_pin;
    logic            indicator_on;
    logic [RunW-1:0] run_state;
  } result_t;

  // encode the one-hot motion state to the run-state code
  function automatic logic [RunW-1:0] run_code(motion_e m);
    logic [RunW-1:0] c;
    case (m)
      ST_AT_A:     c = RUN_AT_A;
      ST_AT_B:     c = RUN_AT_B;
      ST_A_TO_B:   c = RUN_A_TO_B;
      ST_B_TO_A:   c = RUN_B_TO_A;
      ST_PAUSE_AB: c = RUN_PAUSE_AB;
      ST_PAUSE_BA: c = RUN_PAUSE_BA;
      default:     c = RUN_INIT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/lsmc_if.sv =====
// handshake channels: input items, result items and configuration writes
`default_nettype none

interface lsmc_in_if;
  logic            valid;
  logic            ready;
  logic            action;
  logic            touch_pressed;
  logic            limit_a_closed;
  logic            limit_b_closed;
  logic            limit_c_closed;
  logic [9:0]      current_sample;
  logic [9:0]      start_current;

  modport source (output valid, action, touch_pressed, limit_a_closed, limit_b_closed,
                  limit_c_closed, current_sample, start_current, input ready);
  modport sink   (input valid, action, touch_pressed, limit_a_closed, limit_b_closed,
                  limit_c_closed, current_sample, start_current, output ready);
endinterface

interface lsmc_out_if;
  logic       valid;
  logic       ready;
  logic       relay_a_on;
  logic       relay_b_on;
  logic       light_relay_on;
  logic       led_a_pin;
  logic       indicator_on;
  logic [2:0] run_state;

  modport source (output valid, relay_a_on, relay_b_on, light_relay_on, led_a_pin,
                  indicator_on, run_state, input ready);
  modport sink   (input valid, relay_a_on, relay_b_on, light_relay_on, led_a_pin,
                  indicator_on, run_state, output ready);
endinterface

interface lsmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [21:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/lsmc_pass.sv =====
// next-state logic for one item: control pass rules or a millisecond tick
`default_nettype none

module lsmc_pass (
  input  lsmc_pkg::cfg_t       cfg_i,
  input  lsmc_pkg::ctl_state_t state_i,
  input  lsmc_pkg::item_t      item_i,
  output lsmc_pkg::ctl_state_t state_o
);
  import lsmc_pkg::*;

  // stop the motor: arm the light timer if idle, drop both motor relays, clear the reference current
  function automatic ctl_state_t motor_stop(ctl_state_t s);
    ctl_state_t r;
    r = s;
    if (r.light_idle) begin
      r.light_count = '0;
      r.light_idle  = 1'b0;
    end
    r.relay[RLY_A] = 1'b0;
    r.relay[RLY_B] = 1'b0;
    r.ref_current  = '0;
    return r;
  endfunction

  // start the motor in one direction, latch the reference current and idle the light timer
  function automatic ctl_state_t motor_start(ctl_state_t s, logic toward_b,
                                             logic [CurW-1:0] cur);
    ctl_state_t r;
    r = s;
    r.relay[RLY_A] = ~toward_b;
    r.relay[RLY_B] = toward_b;
    r.ref_current  = cur;
    r.light_idle   = 1'b1;
    r.light_count  = '0;
    return r;
  endfunction

  ctl_state_t        s;
  logic [15:0]       diff;
  logic [15:0]       margin;
  logic [16:0]       limit;
  logic [DelayW-1:0] period;
  logic [DelayW-1:0] cnt_inc;

  always_comb begin
    s       = state_i;
    diff    = 16'({6'd0, s.ref_current} - {6'd0, cfg_i.current_offset});
    margin  = '0;
    limit   = '0;
    period  = (cfg_i.light_delay_ms == '0) ? DelayW'(1) : cfg_i.light_delay_ms;
    cnt_inc = s.light_count + DelayW'(1);

    if (item_i.action == ACT_PASS) begin
      // lockout countdown
      if (s.lockout_count > cfg_i.lockout_passes) begin
        s.lockout_count = cfg_i.lockout_passes;
      end
      if (s.lockout_count == '0) begin
        s.touch_locked = 1'b0;
      end else begin
        s.lockout_count = s.lockout_count - LockW'(1);
      end

      // touch rules
      if (item_i.touch_pressed && !s.touch_locked) begin
        s.touch_locked  = 1'b1;
        s.lockout_count = cfg_i.lockout_passes;
        case (s.motion)
          ST_AT_A: begin
            s.motion = ST_A_TO_B;
            s = motor_start(s, 1'b1, item_i.start_current);
          end
          ST_AT_B: begin
            s.motion = ST_B_TO_A;
            s = motor_start(s, 1'b0, item_i.start_current);
          end
          ST_A_TO_B: begin
            s.motion = ST_PAUSE_AB;
            s = motor_stop(s);
          end
          ST_B_TO_A: begin
            s.motion = ST_PAUSE_BA;
            s = motor_stop(s);
          end
          ST_PAUSE_AB: begin
            s.motion = ST_A_TO_B;
            s = motor_start(s, 1'b0, item_i.start_current);
          end
          ST_PAUSE_BA: begin
            s.motion = ST_B_TO_A;
            s = motor_start(s, 1'b1, item_i.start_current);
          end
          default: begin
            s.motion = s.motion;
          end
        endcase
        s.indicator = 1'b1;
      end

      // limit switch A
      if (item_i.limit_a_closed) begin
        s = motor_stop(s);
        s.motion    = ST_AT_A;
        s.led_a_pin = 1'b0;
      end else begin
        s.led_a_pin = 1'b1;
      end

      // limit switch B
      if (item_i.limit_b_closed) begin
        s = motor_stop(s);
        s.motion = ST_AT_B;
      end

      // switch C open while heading to B turns back toward A
      if (!item_i.limit_c_closed && s.motion == ST_A_TO_B) begin
        s.motion = ST_B_TO_A;
        s = motor_start(s, 1'b0, item_i.start_current);
      end

      // obstruction check while heading to A
      diff   = 16'({6'd0, s.ref_current} - {6'd0, cfg_i.current_offset});
      margin = diff >> cfg_i.margin_shift;
      limit  = {7'd0, s.ref_current} + {1'b0, margin};
      if (s.ref_current != '0 && s.motion == ST_B_TO_A &&
          {7'd0, item_i.current_sample} > limit) begin
        s.motion = ST_A_TO_B;
        s = motor_start(s, 1'b1, item_i.start_current);
      end
    end else begin
      // millisecond tick runs the light timer
      if (!s.light_idle) begin
        s.light_count = cnt_inc;
        if (cnt_inc >= period) begin
          s.light_count = '0;
          if (!s.relay[RLY_LIGHT]) begin
            s.relay[RLY_LIGHT] = 1'b1;
          end else begin
            s.relay[RLY_LIGHT] = 1'b0;
            s.light_idle       = 1'b1;
          end
        end
      end
    end
    state_o = s;
  end

endmodule

`default_nettype wire

// ===== src/limit_switch_motor_controller_core.sv =====
// Limit switch motor controller: top level with input, state and result registers.
// Flow: an item is registered at acceptance, and its result is registered when it advances.
// Throughput: one item per cycle while results are taken, each a single pass of lsmc_pass logic.
// Output stall: while a result waits the input register still takes one item, then in ready
// stays low until the result is taken.
// Reset: motion init, relay A on, light timer idle, registers at their defaults.
`default_nettype none

module limit_switch_motor_controller_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  lsmc_in_if.sink       in_i,
  lsmc_out_if.source    out_o,
  lsmc_cfg_if.sink      cfg_i
);
  import lsmc_pkg::*;

  cfg_t       cfg_q;
  ctl_state_t state_q;
  ctl_state_t state_d;
  item_t      item_q;
  logic       in_vld_q;
  logic       out_vld_q;
  result_t    res_q;
  logic       advance;

  // configuration writes always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lockout_passes <= LOCKOUT_RST;
      cfg_q.current_offset <= OFFSET_RST;
      cfg_q.margin_shift   <= SHIFT_RST;
      cfg_q.light_delay_ms <= DELAY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LOCKOUT_PASSES: cfg_q.lockout_passes <= cfg_i.data[LockW-1:0];
        CFG_CURRENT_OFFSET: cfg_q.current_offset <= cfg_i.data[CurW-1:0];
        CFG_MARGIN_SHIFT:   cfg_q.margin_shift   <= cfg_i.data[ShiftW-1:0];
        CFG_LIGHT_DELAY_MS: cfg_q.light_delay_ms <= cfg_i.data[DelayW-1:0];
        default:            cfg_q <= cfg_q;
      endcase
    end
  end

  // pipeline flow control
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.action         <= in_i.action;
      item_q.touch_pressed  <= in_i.touch_pressed;
      item_q.limit_a_closed <= in_i.limit_a_closed;
      item_q.limit_b_closed <= in_i.limit_b_closed;
      item_q.limit_c_closed <= in_i.limit_c_closed;
      item_q.current_sample <= in_i.current_sample;
      item_q.start_current  <= in_i.start_current;
    end
  end

  // next-state logic
  lsmc_pass u_pass (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.motion        <= ST_INIT;
      state_q.lockout_count <= '0;
      state_q.touch_locked  <= 1'b0;
      state_q.ref_current   <= '0;
      state_q.light_idle    <= 1'b1;
      state_q.light_count   <= '0;
      state_q.relay         <= 3'b001;
      state_q.led_a_pin     <= 1'b0;
      state_q.indicator     <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.relay_a_on     <= state_d.relay[RLY_A];
      res_q.relay_b_on     <= state_d.relay[RLY_B];
      res_q.light_relay_on <= state_d.relay[RLY_LIGHT];
      res_q.led_a_pin      <= state_d.led_a_pin;
      res_q.indicator_on   <= state_d.indicator;
      res_q.run_state      <= run_code(state_d.motion);
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.relay_a_on     = res_q.relay_a_on;
  assign out_o.relay_b_on     = res_q.relay_b_on;
  assign out_o.light_relay_on = res_q.light_relay_on;
  assign out_o.led_a_pin      = res_q.led_a_pin;
  assign out_o.indicator_on   = res_q.indicator_on;
  assign out_o.run_state      = res_q.run_state;

  // motor relays agree with the motion state
  a_stopped_relays_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.motion == ST_AT_A || state_q.motion == ST_AT_B ||
     state_q.motion == ST_PAUSE_AB || state_q.motion == ST_PAUSE_BA)
    |-> (!state_q.relay[RLY_A] && !state_q.relay[RLY_B] && state_q.ref_current == '0))
    else $error("motor relay on or reference kept while stopped");

  // a resumed run may drive either way, but always exactly one motor relay
  a_moving_one_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.motion == ST_A_TO_B || state_q.motion == ST_B_TO_A)
    |-> (state_q.relay[RLY_A] ^ state_q.relay[RLY_B]))
    else $error("motor relays wrong while moving");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("controller state changed without an item");

endmodule

`default_nettype wire
